/* rtl/core/b64sc_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and character functions of the base64 stream codec
// no dependencies; every other file of the block but b64sc_if imports this package

package b64sc_pkg;

  // mode register values
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // results one input transaction can cause, and the index width over them
  localparam int MAX_RES = 4;
  localparam int RES_IW  = $clog2(MAX_RES);

  // group queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // characters of the alphabet and padding
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PAD     = 8'h3D;

  // sextet of an invalid character: bit 6 set
  localparam logic [6:0] SEXTET_NONE = 7'd64;

  // one group of results produced by one input transaction
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [RES_IW-1:0]       last_idx;  // index of the final result in the group
    logic                    marker;    // bare end marker, no data
    logic                    str_last;  // group ends the string
  } grp_t;

  // alphabet character of a 6-bit value
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = CH_UPPER_A + {2'b00, v};
    end else if (v < 6'd52) begin
      r = CH_LOWER_A + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      r = CH_DIGIT_0 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      r = CH_PLUS;
    end else begin
      r = CH_SLASH;
    end
    return r;
  endfunction

  // 6-bit value of a character, SEXTET_NONE outside the alphabet
  function automatic logic [6:0] b64_sextet(input logic [7:0] c);
    logic [6:0] r;
    r = SEXTET_NONE;
    case (c) inside
      [CH_UPPER_A:CH_UPPER_Z]: r = 7'(c - CH_UPPER_A);
      [CH_LOWER_A:CH_LOWER_Z]: r = 7'(c - CH_LOWER_A + 8'd26);
      [CH_DIGIT_0:CH_DIGIT_9]: r = 7'(c - CH_DIGIT_0 + 8'd52);
      CH_PLUS:                 r = 7'd62;
      CH_SLASH:                r = 7'd63;
      default:                 r = SEXTET_NONE;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/b64sc_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces of the base64 stream codec
// depends on nothing; used by the front, back and top level

interface b64sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface b64sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output out_valid,
                  output run_last, output string_end, input ready);
  modport sink   (input valid, input out_byte, input out_valid,
                  input run_last, input string_end, output ready);
endinterface

/* rtl/core/b64sc_front.sv */
`timescale 1ns / 1ps
// front end: accepts input transactions, holds the string state, builds result groups
// depends on b64sc_pkg and b64sc_in_if

module b64sc_front import b64sc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  b64sc_in_if.sink        in_chan,
  input  logic            q_full,
  output logic            q_push,
  output grp_t            q_grp
);

  logic        mode_r;
  logic [11:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [1:0]  cm4_r, cm4_nxt;
  logic        pad_r, pad_nxt;

  logic                    accept;
  logic                    last;
  logic [MAX_RES-1:0][7:0] res;
  logic [2:0]              k;
  logic [19:0]             e_wide;
  logic [4:0]              e_n;
  logic [4:0]              n_left;
  logic [1:0]              cmv;
  logic [6:0]              v;
  logic [17:0]             d_wide;
  logic [4:0]              d_n;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign last          = in_chan.is_last;

  always_comb begin
    res     = '0;
    k       = 3'd0;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    cm4_nxt = cm4_r;
    pad_nxt = pad_r;
    e_wide  = {acc_r[11:0], in_chan.in_byte};
    e_n     = {1'b0, cnt_r} + 5'd8;
    n_left  = e_n;
    cmv     = cm4_r;
    v       = b64_sextet(in_chan.in_byte);
    d_wide  = {acc_r, v[5:0]};
    d_n     = {1'b0, cnt_r} + 5'd6;
    if (mode_r == MODE_ENCODE) begin
      if (n_left >= 5'd6) begin
        res[k[RES_IW-1:0]] = b64_char(6'(e_wide >> (n_left - 5'd6)));
        k      = k + 3'd1;
        n_left = n_left - 5'd6;
      end
      if (n_left >= 5'd6) begin
        res[k[RES_IW-1:0]] = b64_char(6'(e_wide >> (n_left - 5'd6)));
        k      = k + 3'd1;
        n_left = n_left - 5'd6;
      end
      acc_nxt = e_wide[11:0];
      cnt_nxt = n_left[3:0];
      cmv     = cm4_r + k[1:0];
      if (last) begin
        // flush partial group padded with zero bits
        if (n_left != 5'd0) begin
          res[k[RES_IW-1:0]] = b64_char(6'({acc_nxt, 6'd0} >> n_left));
          k   = k + 3'd1;
          cmv = cmv + 2'd1;
        end
        for (int i = 0; i < 3; i++) begin
          if (cmv != 2'd0 && k < 3'(MAX_RES)) begin
            res[k[RES_IW-1:0]] = CH_PAD;
            k   = k + 3'd1;
            cmv = cmv + 2'd1;
          end
        end
      end
      cm4_nxt = cmv;
    end else if (!pad_r) begin
      if (v[6]) begin
        if (in_chan.in_byte == CH_PAD) begin
          pad_nxt = 1'b1;
        end
      end else begin
        if (d_n >= 5'd8) begin
          res[0] = 8'(d_wide >> (d_n - 5'd8));
          k      = 3'd1;
          d_n    = d_n - 5'd8;
        end
        acc_nxt = d_wide[11:0];
        cnt_nxt = d_n[3:0];
      end
    end
    if (last) begin
      acc_nxt = '0;
      cnt_nxt = '0;
      cm4_nxt = '0;
      pad_nxt = 1'b0;
    end
  end

  assign q_push         = accept && (k != 3'd0 || last);
  assign q_grp.bytes    = res;
  assign q_grp.last_idx = (k == 3'd0) ? '0 : RES_IW'(k - 3'd1);
  assign q_grp.marker   = (k == 3'd0);
  assign q_grp.str_last = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
      acc_r  <= '0;
      cnt_r  <= '0;
      cm4_r  <= '0;
      pad_r  <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
      acc_r  <= '0;
      cnt_r  <= '0;
      cm4_r  <= '0;
      pad_r  <= 1'b0;
    end else if (accept) begin
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      cm4_r  <= cm4_nxt;
      pad_r  <= pad_nxt;
    end
  end

endmodule

/* rtl/core/b64sc_queue.sv */
`timescale 1ns / 1ps
// short queue of result groups between the front and back ends
// depends on b64sc_pkg

module b64sc_queue import b64sc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t push_grp,
  input  logic pop,
  output grp_t head_grp,
  output logic full,
  output logic empty
);

  grp_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;

  assign full     = (count_r == Q_CW'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign head_grp = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? Q_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? Q_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("group pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("group popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a lone push");

endmodule

/* rtl/core/b64sc_back.sv */
`timescale 1ns / 1ps
// back end: walks each result group and drives the output register
// depends on b64sc_pkg and b64sc_out_if

module b64sc_back import b64sc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  grp_t          head_grp,
  input  logic          q_empty,
  output logic          q_pop,
  b64sc_out_if.source   out_chan
);

  logic [RES_IW-1:0] idx_r, idx_nxt;
  logic              vld_r, vld_nxt;
  logic [7:0]        byte_r;
  logic              oval_r;
  logic              rlast_r;
  logic              send_r;
  logic              load;
  logic              final_one;

  assign load      = !vld_r || out_chan.ready;
  assign final_one = (idx_r == head_grp.last_idx);
  assign q_pop     = load && !q_empty && final_one;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = !q_empty;
      if (!q_empty) begin
        idx_nxt = final_one ? '0 : RES_IW'(idx_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      byte_r  <= head_grp.marker ? 8'd0 : head_grp.bytes[idx_r];
      oval_r  <= !head_grp.marker;
      rlast_r <= final_one;
      send_r  <= final_one && head_grp.str_last;
    end
  end

  assign out_chan.valid      = vld_r;
  assign out_chan.out_byte   = byte_r;
  assign out_chan.out_valid  = oval_r;
  assign out_chan.run_last   = rlast_r;
  assign out_chan.string_end = send_r;

  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> idx_r <= head_grp.last_idx)
    else $error("result index past end of group");

  a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> idx_r == '0)
    else $error("index not restarted after group");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && send_r |-> rlast_r)
    else $error("string end on a result that is not the last of its transaction");

endmodule

/* rtl/core/base64_stream_codec.sv */
`timescale 1ns / 1ps
// top level of the base64 stream codec (standard alphabet)
// depends on b64sc_pkg, b64sc_if, b64sc_front, b64sc_queue and b64sc_back
//
// usage
//   in_chan carries one string byte per transaction with is_last on the final
//   byte; out_chan returns characters (encode) or data bytes (decode) with
//   run_last on the last result of each input transaction and string_end on
//   the last result of the string. a decode string whose final byte makes no
//   output returns one bare end marker (out_valid 0, out_byte 0)
//   cfg_we/cfg_wdata write the mode (0 encode, 1 decode) and clear the string
//   state; write only while the block is idle
// dataflow
//   an input transaction is taken in any cycle the group queue has room; its
//   group is written to the queue, and the back end loads the results from the
//   queue head into the output register, where out_chan takes them
//   the back end emits one result per cycle while out_chan is ready; an item
//   makes at most 4 results at string end, about 1.33 per byte sustained when
//   encoding; the output channel sets the sustained rate
// reset
//   rst_n (synchronous, active low) selects encode mode, clears the string
//   state and empties the queue and output register
// stalls
//   when out_chan is not ready the output register holds its result, the
//   queue fills and in_chan.ready drops once all four queue entries are taken

module base64_stream_codec import b64sc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  b64sc_in_if.sink      in_chan,
  b64sc_out_if.source   out_chan
);

  // front to queue
  logic q_push;
  grp_t q_grp;
  logic q_full;

  // queue to back
  grp_t head_grp;
  logic q_empty;
  logic q_pop;

  // front: classifies each transaction and builds its whole result group
  b64sc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_grp     (q_grp)
  );

  // queue: decouples intake from the output side
  b64sc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_grp (q_grp),
    .pop      (q_pop),
    .head_grp (head_grp),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: serializes groups one result per cycle, while out_chan is ready, into the output register
  b64sc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_grp (head_grp),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench of base64_stream_codec, encode and decode modes
// depends on b64sc_pkg, b64sc_if and the codec top level under rtl/core

module testbench;
  import b64sc_pkg::*;

  // alphabet in index order, 'A' in the top byte
  localparam logic [0:63][7:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // items per random phase and number of random phases
  localparam int PHASE_ITEMS = 54;
  localparam int N_PHASES    = 6;

  // one input transaction: string byte and end-of-string flag
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // one output transaction as the codec should present it
  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic       run_end;
    logic       str_end;
  } res_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic cfg_we    = 1'b0;
  logic cfg_wdata = 1'b0;

  b64sc_in_if  in_chan ();
  b64sc_out_if out_chan ();

  base64_stream_codec u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bytes waiting to be sent, and characters or bytes still to come out
  item_t      byte_queue[$];
  res_t       expected_out[$];
  logic [7:0] str_buf[$];

  // predictor copy of the codec state
  logic        cur_mode;
  logic [11:0] acc_bits;
  logic [3:0]  acc_len;
  logic [1:0]  char_phase;
  logic        pad_hit;
  logic [7:0]  emit_buf[MAX_RES];
  int          emit_n;

  int errors       = 0;
  int queued_items = 0;

  // sender and receiver pacing
  bit          in_took    = 1'b0;
  int          burst_left = 1;
  int          gap_left   = 0;
  int          gap_max    = 0;
  logic [15:0] ready_pat  = 16'hFFFF;
  int          pat_pos    = 0;
  res_t        got;

  // 6-bit value of a text character, SEXTET_NONE outside the alphabet
  function automatic logic [6:0] char_value(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return 7'(c - CH_UPPER_A);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return 7'(c - CH_LOWER_A + 8'd26);
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return 7'(c - CH_DIGIT_0 + 8'd52);
    if (c == CH_PLUS) return 7'd62;
    if (c == CH_SLASH) return 7'd63;
    return SEXTET_NONE;
  endfunction

  // random character the decoder must skip, never the pad character
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (char_value(c) != SEXTET_NONE || c == CH_PAD) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic clear_string_state();
    acc_bits   = '0;
    acc_len    = '0;
    char_phase = '0;
    pad_hit    = 1'b0;
  endtask

  task automatic emit_raw(input logic [7:0] b);
    if (emit_n < MAX_RES) begin
      emit_buf[emit_n] = b;
      emit_n++;
    end
  endtask

  task automatic emit_char(input logic [5:0] v);
    emit_raw(B64_ALPHABET[v]);
    char_phase++;
  endtask

  task automatic emit_pad();
    emit_raw(CH_PAD);
    char_phase++;
  endtask

  // expected output transactions of one accepted input transaction
  task automatic codec_step(input logic [7:0] c, input logic last);
    int          n;
    int          k;
    logic [19:0] wide;
    logic [17:0] w6;
    logic [6:0]  v;
    res_t        r;
    emit_n = 0;
    if (cur_mode == MODE_ENCODE) begin
      wide = {acc_bits, c};
      n = acc_len + 8;
      while (n >= 6) begin
        emit_char(6'(wide >> (n - 6)));
        n -= 6;
      end
      acc_bits = wide[11:0];
      acc_len  = 4'(n);
      if (last) begin
        // flush the partial group with zero fill, then pad to four
        if (acc_len != 0) begin
          w6 = {6'b0, acc_bits} << (6 - acc_len);
          emit_char(w6[5:0]);
        end
        while (char_phase != 0) emit_pad();
      end
    end else if (!pad_hit) begin
      v = char_value(c);
      if (v == SEXTET_NONE) begin
        if (c == CH_PAD) pad_hit = 1'b1;
      end else begin
        w6 = {acc_bits, v[5:0]};
        n = acc_len + 6;
        if (n >= 8) begin
          wide = 20'(w6 >> (n - 8));
          emit_raw(wide[7:0]);
          n -= 8;
        end
        acc_bits = w6[11:0];
        acc_len  = 4'(n);
      end
    end
    if (emit_n == 0) begin
      // end of a decode string whose last transaction made no byte: bare end marker
      if (last) begin
        r = '{data: 8'h00, dvalid: 1'b0, run_end: 1'b1, str_end: 1'b1};
        expected_out.insert(expected_out.size(), r);
      end
    end else begin
      for (k = 0; k < emit_n; k++) begin
        r.data    = emit_buf[k];
        r.dvalid  = 1'b1;
        r.run_end = (k == emit_n - 1);
        r.str_end = (k == emit_n - 1) && last;
        expected_out.insert(expected_out.size(), r);
      end
    end
    if (last) clear_string_state();
  endtask

  task automatic report_mismatch(input string what, input res_t e, input res_t a);
    errors++;
    if (errors <= 10) begin
      $display("mismatch (%s) at %0t: expected byte %h valid %b run_last %b end %b,",
               what, $realtime, e.data, e.dvalid, e.run_end, e.str_end);
      $display("  got byte %h valid %b run_last %b end %b",
               a.data, a.dvalid, a.run_end, a.str_end);
    end
  endtask

  // input side: track accepted transactions and mode writes in the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took  = 1'b0;
      cur_mode = MODE_ENCODE;
      clear_string_state();
    end else begin
      in_took = in_chan.valid && in_chan.ready;
      // a mode write also clears the string state
      if (cfg_we) begin
        cur_mode = cfg_wdata;
        clear_string_state();
      end
      if (in_took) codec_step(in_chan.in_byte, in_chan.is_last);
    end
  end

  // driver: bursts of transactions with random gaps, changes on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid   <= 1'b0;
      in_chan.in_byte <= 8'h00;
      in_chan.is_last <= 1'b0;
    end else if (in_chan.valid && !in_took) begin
      // hold the offered transaction until the codec takes it
    end else if (gap_left > 0) begin
      in_chan.valid <= 1'b0;
      gap_left--;
    end else if (byte_queue.size() != 0) begin
      in_chan.valid   <= 1'b1;
      in_chan.in_byte <= byte_queue[0].data;
      in_chan.is_last <= byte_queue[0].last;
      byte_queue.pop_front();
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 12);
        gap_left   = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      end else begin
        burst_left--;
      end
    end else begin
      in_chan.valid <= 1'b0;
    end
  end

  // receiver ready follows a rotating pattern set per phase
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ready_pat[pat_pos];
      pat_pos = (pat_pos + 1) % 16;
    end
  end

  // monitor: every output transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.data    = out_chan.out_byte;
      got.dvalid  = out_chan.out_valid;
      got.run_end = out_chan.run_last;
      got.str_end = out_chan.string_end;
      if (expected_out.size() == 0) begin
        report_mismatch("unexpected", '0, got);
      end else begin
        if (got != expected_out[0]) report_mismatch("field", expected_out[0], got);
        expected_out.pop_front();
      end
    end
  end

  // append one byte to the string being built
  task automatic add_char(input logic [7:0] c);
    str_buf.insert(str_buf.size(), c);
  endtask

  // move the string being built to the send queue, last byte flagged
  task automatic flush_string();
    item_t it;
    int    i;
    for (i = 0; i < str_buf.size(); i++) begin
      it.data = str_buf[i];
      it.last = (i == str_buf.size() - 1);
      byte_queue.insert(byte_queue.size(), it);
      queued_items++;
    end
    str_buf.delete();
  endtask

  // main sequence waits until every byte is sent and every expected transaction
  // has come out
  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_chan.valid || expected_out.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_traffic(input int gmax, input logic [15:0] pat);
    gap_max   = gmax;
    ready_pat = pat | 16'h0001;
  endtask

  // one random string for the given mode
  task automatic gen_string(input logic m);
    int len;
    int kind;
    int groups;
    int pads;
    int i;
    if (m == MODE_ENCODE) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      for (i = 0; i < len; i++) add_char(8'($urandom_range(0, 255)));
    end else begin
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        // well-formed text, some of it with junk characters mixed in
        groups = $urandom_range(1, 3);
        pads   = $urandom_range(0, 2);
        for (i = 0; i < 4 * groups; i++) begin
          if (kind >= 70 && $urandom_range(0, 4) == 0) add_char(junk_char());
          if (i >= 4 * groups - pads) add_char(CH_PAD);
          else add_char(B64_ALPHABET[$urandom_range(0, 63)]);
        end
      end else begin
        // raw noise, any byte value
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) add_char(8'($urandom_range(0, 255)));
      end
    end
    flush_string();
  endtask

  initial begin : main
    int   ph;
    int   start;
    logic m;
    in_chan.valid   = 1'b0;
    in_chan.in_byte = 8'h00;
    in_chan.is_last = 1'b0;
    out_chan.ready  = 1'b0;

    // reset asserted at start, released on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed encode: single zero byte, two and three byte groups, a four byte string with + and /
    write_mode(MODE_ENCODE);
    set_traffic(3, 16'hB5D7);
    str_buf = '{8'h00};
    flush_string();
    str_buf = '{8'hFF, 8'h00};
    flush_string();
    str_buf = '{"M", "a", "n"};
    flush_string();
    str_buf = '{8'hFB, 8'hFF, 8'hBF, 8'h80};
    flush_string();
    wait_idle();

    // directed decode: padded group ending in a bare end marker, lone invalid
    // character, text after the first pad, skipped high byte
    write_mode(MODE_DECODE);
    set_traffic(2, 16'h6F3B);
    str_buf = '{"Q", "Q", "=", "="};
    flush_string();
    str_buf = '{"@"};
    flush_string();
    str_buf = '{"Q", "=", "Q", "Q"};
    flush_string();
    str_buf = '{"9", 8'hFF, "+", "/", "a"};
    flush_string();
    wait_idle();

    // random phases in both modes and with varied pacing
    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          m = MODE_ENCODE;
          set_traffic(0, 16'hFFFF);
        end
        1: begin
          m = MODE_DECODE;
          set_traffic(6, 16'($urandom));
        end
        2: begin
          m = MODE_ENCODE;
          set_traffic(3, 16'h0421);
        end
        3: begin
          m = MODE_DECODE;
          set_traffic(8, 16'($urandom));
        end
        4: begin
          m = MODE_DECODE;
          set_traffic(0, 16'($urandom));
        end
        default: begin
          m = MODE_ENCODE;
          set_traffic(5, 16'hFFFF);
        end
      endcase
      write_mode(m);
      start = queued_items;
      while (queued_items - start < PHASE_ITEMS) gen_string(m);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_out.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
